FILE: rtl/lgs_pkg.sv
// shared types and constants for the life generation stencil
// no dependencies; used by every module of the block except lgs_ram
package lgs_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd130;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd130;

  // smallest padded dimension: one interior cell plus the halo
  localparam int MIN_DIM = 3;

  // life rule thresholds
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // one window column: bit 0 row r-2, bit 1 row r-1, bit 2 current row
  localparam int COL_TOP = 0;
  localparam int COL_MID = 1;
  localparam int COL_BOT = 2;

  typedef logic [2:0] col_t;

endpackage

FILE: rtl/lgs_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module lgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lgs_column_cell.sv
// one cell of the window chain: holds one 3-bit column, passes it on each item
// depends on lgs_pkg
module lgs_column_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  lgs_pkg::col_t col_in,
  output lgs_pkg::col_t col_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

FILE: rtl/lgs_rule.sv
// life rule over a 3x3 window given as three columns, oldest first
// depends on lgs_pkg
module lgs_rule (
  input  lgs_pkg::col_t col_old,
  input  lgs_pkg::col_t col_mid,
  input  lgs_pkg::col_t col_new,
  output logic          alive
);

  logic [7:0] nbrs;
  logic [3:0] count;
  logic       centre;

  assign centre = col_mid[lgs_pkg::COL_MID];
  assign nbrs = {col_old, col_new,
                 col_mid[lgs_pkg::COL_TOP], col_mid[lgs_pkg::COL_BOT]};

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nbrs[i]);
    end
  end

  assign alive = (count == lgs_pkg::BIRTH_COUNT) ||
                 ((count == lgs_pkg::SURVIVE_COUNT) && centre);

endmodule

FILE: rtl/life_generation_stencil.sv
// top level of the life generation stencil: counters, line buffer, window chain, output stage
// depends on lgs_pkg, lgs_ram, lgs_column_cell, lgs_rule
//
// Takes one padded block (interior plus a one-cell halo ring) as a raster
// stream of single-bit cells, one item per clock, and returns the next
// generation of every interior cell, (frame_width-2)*(frame_height-2) items per
// frame, flagged at the end of each output row and of the frame. Throughput is
// one item per cycle while out_stall is low; a result is registered from the
// item completing its window. The two line buffers share one RAM, two bits wide and
// MAX_WIDTH deep; its registered read is fed with the column the next item will
// land on, so the rows above are ready when that item arrives. A two-entry output
// stage takes one extra result while the output is stalled, so in_stall is a
// plain register. Line buffer contents are not cleared by reset; the first two
// rows of a frame fill them before any result depends on them. Frame size is set
// through the cfg port (index 0 frame_width, index 1 frame_height, both clamped
// to 3..MAX); write it only while the block is idle.
module life_generation_stencil #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input cells
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cell_in,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             next_cell,
  output logic                             end_of_row,
  output logic                             end_of_frame
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  // compare widths wide enough for both the register and the limit
  localparam int WCMP = (COL_W + 1 > lgs_pkg::FRAME_WIDTH_W) ?
                        COL_W + 1 : lgs_pkg::FRAME_WIDTH_W;
  localparam int HCMP = (ROW_W + 1 > lgs_pkg::FRAME_HEIGHT_W) ?
                        ROW_W + 1 : lgs_pkg::FRAME_HEIGHT_W;

  // configuration registers
  logic [lgs_pkg::FRAME_WIDTH_W-1:0]  frame_width;
  logic [lgs_pkg::FRAME_HEIGHT_W-1:0] frame_height;

  // raster position of the next item
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  // output stage: visible register plus one skid entry
  logic skid_valid, skid_cell, skid_eor, skid_eof;

  logic             accept;
  logic [WCMP-1:0]  fw_ext, w_clamped, col_last;
  logic [HCMP-1:0]  fh_ext, h_clamped, row_last;
  logic             last_col, last_row, produce;
  logic [COL_W-1:0] raddr;
  logic [1:0]       line_rd;
  lgs_pkg::col_t    col_new, col_a, col_b;
  logic             alive;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;

  // config writes, taken whenever offered
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lgs_pkg::FRAME_WIDTH_RST;
      frame_height <= lgs_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lgs_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[lgs_pkg::FRAME_WIDTH_W-1:0];
        end
        lgs_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[lgs_pkg::FRAME_HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp the frame size and find the last column and row index
  assign fw_ext = WCMP'(frame_width);
  assign fh_ext = HCMP'(frame_height);

  always_comb begin
    if (fw_ext < WCMP'(lgs_pkg::MIN_DIM)) begin
      w_clamped = WCMP'(lgs_pkg::MIN_DIM);
    end else if (fw_ext > WCMP'(MAX_WIDTH)) begin
      w_clamped = WCMP'(MAX_WIDTH);
    end else begin
      w_clamped = fw_ext;
    end
    if (fh_ext < HCMP'(lgs_pkg::MIN_DIM)) begin
      h_clamped = HCMP'(lgs_pkg::MIN_DIM);
    end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
      h_clamped = HCMP'(MAX_HEIGHT);
    end else begin
      h_clamped = fh_ext;
    end
  end

  assign col_last = w_clamped - WCMP'(1);
  assign row_last = h_clamped - HCMP'(1);
  assign last_col = WCMP'(column_count) >= col_last;
  assign last_row = HCMP'(row_count) >= row_last;

  // a result exists once the window holds three rows and three columns
  assign produce = (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));

  // raster counters; a lowered frame size closes the row or frame at once
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + ROW_W'(1);
    end else begin
      column_count_next = column_count + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // line buffer: bit 1 row r-2, bit 0 row r-1, indexed by column
  // read the column of the next item so its data is registered in time;
  // the write goes to the current column, never the same address
  assign raddr = accept ? column_count_next : column_count;

  lgs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (column_count),
    .wdata ({line_rd[0], cell_in}),
    .raddr (raddr),
    .rdata (line_rd)
  );

  // column entering the window this item
  always_comb begin
    col_new = '0;
    col_new[lgs_pkg::COL_TOP] = line_rd[1];
    col_new[lgs_pkg::COL_MID] = line_rd[0];
    col_new[lgs_pkg::COL_BOT] = cell_in;
  end

  // window chain: col_a newest stored column, col_b the one before
  lgs_column_cell u_cell_a (
    .clk     (clk),
    .rst     (rst),
    .shift   (accept),
    .col_in  (col_new),
    .col_out (col_a)
  );

  lgs_column_cell u_cell_b (
    .clk     (clk),
    .rst     (rst),
    .shift   (accept),
    .col_in  (col_a),
    .col_out (col_b)
  );

  // centre of the window is the middle of col_a
  lgs_rule u_rule (
    .col_old (col_b),
    .col_mid (col_a),
    .col_new (col_new),
    .alive   (alive)
  );

  // output register with skid entry; input stalls only while the skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && produce;
      end
    end else if (accept && produce) begin
      skid_valid <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        next_cell    <= skid_cell;
        end_of_row   <= skid_eor;
        end_of_frame <= skid_eof;
      end else begin
        next_cell    <= alive;
        end_of_row   <= last_col;
        end_of_frame <= last_col && last_row;
      end
    end
    if (out_valid && out_stall && accept && produce) begin
      skid_cell <= alive;
      skid_eor  <= last_col;
      skid_eof  <= last_col && last_row;
    end
  end

endmodule
